### src/pngusf_pkg.sv
// Shared types and codes for the premultiplied RGBA Sub/Up row filter.
package pngusf_pkg;

  // Item kinds on the input channel
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Filter codes in the type result
  localparam logic [1:0] FILTER_NONE = 2'd0;
  localparam logic [1:0] FILTER_SUB  = 2'd1;
  localparam logic [1:0] FILTER_UP   = 2'd2;

  // Quotient bits produced by the divider
  localparam int DIV_STEPS = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_DCALC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       is_type_byte;
    logic [1:0] filter_code;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       end_of_row;
  } res_t;

endpackage

### src/pngusf_if.sv
// Valid/ready channel interfaces for pixel words in and filtered words out.
interface pngusf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, kind, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface pngusf_out_if;
  logic       valid;
  logic       ready;
  logic       is_type_byte;
  logic [1:0] filter_code;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       end_of_row;

  modport source (output valid, is_type_byte, filter_code, red_out, green_out, blue_out,
                  alpha_out, end_of_row, input ready);
  modport sink (input valid, is_type_byte, filter_code, red_out, green_out, blue_out,
                alpha_out, end_of_row, output ready);
endinterface

### src/png_unpremultiply_sub_up_filter.sv
// Top level of the premultiplied RGBA adaptive Sub/Up row filter.
// Each pixel word is un-premultiplied, stored in a row memory and scored
// against its Sub and Up predictions; the row before it leaves one row late,
// led by its filter-type word. A pixel word goes from accept through a memory
// read, the bit-serial alpha divider (one quotient bit per cycle, three colors
// in parallel) and an update state to the emit state, which hands results to
// the output register, waiting while it is full. A drain word that emits passes
// the drain calculate state (unless it sends only a type word) and the emit
// state; a drain with no pending row and a pixel dropped in a drain leave the
// sequencer idle. Both memories are read once per pixel word; the older-role
// one takes the word and the other is zeroed on the first row only. The output
// register lets a finished word wait while the next input is taken.
module png_unpremultiply_sub_up_filter
  import pngusf_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [12:0]  cfg_wdata_i,
  pngusf_in_if.sink    in_i,
  pngusf_out_if.source out_o
);

  localparam int XW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int CW = XW + 10;

  // Row memories: mem0 is the older store while sel_q is low, mem1 while it is high
  logic [31:0] mem0 [MAX_ROW_PIXELS];
  logic [31:0] mem1 [MAX_ROW_PIXELS];
  logic [31:0] rd0_q, rd1_q;

  state_e state_q, state_d;
  logic [12:0]   width_q;
  logic [XW-1:0] col_q, x_q, dpos_q;
  logic          first_q, sel_q, dact_q, rowp_q, last_q;
  logic [CW-1:0] sub_q, up_q;
  logic [1:0]    pend_q;
  logic [31:0]   prev_q, left_q;
  logic [7:0]    alpha_q;
  logic [7:0]    rem_q [3];
  logic [7:0]    lo_q [3];
  logic [7:0]    quo_q [3];
  logic [2:0]    sat_q;
  logic [2:0]    cnt_q;
  logic          type_need_q, pix_need_q, out_valid_q;
  res_t          type_q, pix_q, out_q;

  logic          accept, slot_free, rd_en, we0, we1, last_a;
  logic [XW-1:0] rd_addr;
  logic [31:0]   wd0, wd1, newer_rd, older_rd, word, left_w, above_w, eff_w;
  logic [7:0]    chan [3];
  logic [7:0]    cin [3];
  logic [9:0]    cost_sub, cost_up;
  logic [CW-1:0] sub_n, up_n;
  res_t          pix_w;

  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign newer_rd  = sel_q ? rd0_q : rd1_q;
  assign older_rd  = sel_q ? rd1_q : rd0_q;
  assign cin[0]    = in_i.red_in;
  assign cin[1]    = in_i.green_in;
  assign cin[2]    = in_i.blue_in;

  // Clamp the row width to between one and the memory depth
  always_comb begin
    eff_w = 32'(width_q);
    if (eff_w == 32'd0) eff_w = 32'd1;
    if (eff_w > 32'(MAX_ROW_PIXELS)) eff_w = 32'(MAX_ROW_PIXELS);
  end

  // Read address: pixel column, or next drain position
  assign rd_addr = (in_i.kind == KIND_DRAIN && dact_q) ? dpos_q : col_q;
  assign last_a  = (32'(rd_addr) + 32'd1 >= eff_w);

  // Finish the un-premultiply and score both predictions
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (alpha_q == 8'd0) chan[k] = 8'd0;
      else if (sat_q[k]) chan[k] = 8'hFF;
      else chan[k] = quo_q[k];
    end
    word    = {alpha_q, chan[2], chan[1], chan[0]};
    left_w  = (x_q == '0) ? 32'd0 : left_q;
    above_w = first_q ? 32'd0 : newer_rd;
    cost_sub = '0;
    cost_up  = '0;
    for (int k = 0; k < 4; k++) begin
      logic [7:0] ds, du;
      ds = word[8*k +: 8] - left_w[8*k +: 8];
      du = word[8*k +: 8] - above_w[8*k +: 8];
      cost_sub = cost_sub + 10'(ds[7] ? 8'(-ds) : ds);
      cost_up  = cost_up + 10'(du[7] ? 8'(-du) : du);
    end
    sub_n = sub_q + CW'(cost_sub);
    up_n  = up_q + CW'(cost_up);
  end

  // Filtered pixel of the pending row at column x_q
  always_comb begin
    logic [31:0] pred;
    pred = (pend_q == FILTER_UP) ? older_rd : ((x_q == '0) ? 32'd0 : prev_q);
    pix_w.is_type_byte = 1'b0;
    pix_w.filter_code  = FILTER_NONE;
    pix_w.red_out      = newer_rd[7:0] - pred[7:0];
    pix_w.green_out    = newer_rd[15:8] - pred[15:8];
    pix_w.blue_out     = newer_rd[23:16] - pred[23:16];
    pix_w.alpha_out    = newer_rd[31:24] - pred[31:24];
    pix_w.end_of_row   = last_q;
  end

  // Sequencer: next state and memory strobes
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    we0     = 1'b0;
    we1     = 1'b0;
    wd0     = word;
    wd1     = word;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (in_i.kind == KIND_PIXEL) begin
            if (!dact_q) state_d = ST_DIV;
          end else if (dact_q || rowp_q) begin
            state_d = (!dact_q && col_q == '0) ? ST_EMIT : ST_DCALC;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == 3'(DIV_STEPS - 1)) state_d = ST_UPD;
      end
      ST_UPD: begin
        // Older role takes the new word; first row zeroes the newer role
        if (sel_q) begin
          we1 = 1'b1;
          we0 = first_q;
          wd0 = 32'd0;
        end else begin
          we0 = 1'b1;
          we1 = first_q;
          wd1 = 32'd0;
        end
        state_d = ST_EMIT;
      end
      ST_DCALC: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!type_need_q && !pix_need_q) state_d = ST_IDLE;
        else if (slot_free && (type_need_q ? !pix_need_q : 1'b1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Row memories
  always_ff @(posedge clk_i) begin
    if (we0) mem0[x_q] <= wd0;
    if (we1) mem1[x_q] <= wd1;
    if (rd_en) begin
      rd0_q <= mem0[rd_addr];
      rd1_q <= mem1[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) width_q <= 13'd1;
    else if (cfg_we_i) width_q <= cfg_wdata_i;
  end

  // Item datapath: divider setup and steps
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      x_q     <= rd_addr;
      last_q  <= last_a;
      alpha_q <= in_i.alpha_in;
      cnt_q   <= '0;
      for (int k = 0; k < 3; k++) begin
        logic [15:0] n;
        n = {cin[k], 8'h00} - {8'h00, cin[k]} + {9'h000, in_i.alpha_in[7:1]};
        rem_q[k] <= n[15:8];
        lo_q[k]  <= n[7:0];
        sat_q[k] <= (n[15:8] >= in_i.alpha_in);
      end
    end else if (state_q == ST_DIV) begin
      cnt_q <= cnt_q + 3'd1;
      for (int k = 0; k < 3; k++) begin
        logic [8:0] t;
        t = {rem_q[k], lo_q[k][7]};
        if (t >= {1'b0, alpha_q}) begin
          rem_q[k] <= 8'(t - {1'b0, alpha_q});
          quo_q[k] <= {quo_q[k][6:0], 1'b1};
        end else begin
          rem_q[k] <= t[7:0];
          quo_q[k] <= {quo_q[k][6:0], 1'b0};
        end
        lo_q[k] <= {lo_q[k][6:0], 1'b0};
      end
    end
  end

  // Payload holding registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      type_q              <= '0;
      type_q.is_type_byte <= 1'b1;
      type_q.filter_code  <= pend_q;
    end
    if (state_q == ST_UPD || state_q == ST_DCALC) begin
      pix_q  <= pix_w;
      prev_q <= newer_rd;
    end
    if (state_q == ST_UPD) left_q <= word;
    if (state_q == ST_EMIT && slot_free) begin
      if (type_need_q) out_q <= type_q;
      else if (pix_need_q) out_q <= pix_q;
    end
  end

  // Row, cost and drain control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_q     <= 1'b1;
      sel_q       <= 1'b0;
      sub_q       <= '0;
      up_q        <= '0;
      pend_q      <= FILTER_NONE;
      dact_q      <= 1'b0;
      dpos_q      <= '0;
      rowp_q      <= 1'b0;
      type_need_q <= 1'b0;
      pix_need_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Load the output word from the emit state, else drop it once taken
      if (state_q == ST_EMIT && slot_free && (type_need_q || pix_need_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && in_i.kind == KIND_DRAIN && !dact_q) begin
            if (!rowp_q) begin
              // Nothing pending: drop partial row, start new image
              first_q <= 1'b1;
              col_q   <= '0;
              sub_q   <= '0;
              up_q    <= '0;
              pend_q  <= FILTER_NONE;
            end else if (col_q == '0) begin
              type_need_q <= 1'b1;
              dact_q      <= 1'b1;
              dpos_q      <= '0;
            end
          end
        end
        ST_UPD: begin
          type_need_q <= rowp_q && (x_q == '0);
          pix_need_q  <= rowp_q;
          if (last_q) begin
            pend_q  <= (up_n < sub_n) ? FILTER_UP : FILTER_SUB;
            sub_q   <= '0;
            up_q    <= '0;
            col_q   <= '0;
            sel_q   <= ~sel_q;
            first_q <= 1'b0;
            rowp_q  <= 1'b1;
          end else begin
            sub_q <= sub_n;
            up_q  <= up_n;
            col_q <= x_q + XW'(1);
          end
        end
        ST_DCALC: begin
          pix_need_q <= 1'b1;
          if (last_q) begin
            first_q <= 1'b1;
            rowp_q  <= 1'b0;
            col_q   <= '0;
            sub_q   <= '0;
            up_q    <= '0;
            pend_q  <= FILTER_NONE;
            dact_q  <= 1'b0;
          end else begin
            dact_q <= 1'b1;
            dpos_q <= x_q + XW'(1);
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (type_need_q) type_need_q <= 1'b0;
            else if (pix_need_q) pix_need_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output word
  assign out_o.valid        = out_valid_q;
  assign out_o.is_type_byte = out_q.is_type_byte;
  assign out_o.filter_code  = out_q.filter_code;
  assign out_o.red_out      = out_q.red_out;
  assign out_o.green_out    = out_q.green_out;
  assign out_o.blue_out     = out_q.blue_out;
  assign out_o.alpha_out    = out_q.alpha_out;
  assign out_o.end_of_row   = out_q.end_of_row;

endmodule
